@@ hw/rtl/drtbs_pkg.sv @@
package drtbs_pkg;

  // Field and datapath widths
  localparam int OPCODE_W    = 2;
  localparam int LEN_W       = 16;
  localparam int TIME_W      = 63;
  localparam int STATUS_W    = 3;
  localparam int BYTES_W     = 32;
  localparam int RATE_W      = 40;
  localparam int TOKEN_W     = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 40;

  // len * 1e9 stays below 2^46 for any 16-bit length
  localparam int PRODUCT_W = 46;
  localparam int DIV_CNT_W = $clog2(PRODUCT_W);

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // Reset values of the configuration registers
  localparam logic [RATE_W-1:0]  RATE_RESET      = RATE_W'(125000000);
  localparam logic [RATE_W-1:0]  PEAK_RESET      = '0;
  localparam logic [TOKEN_W-1:0] DEPTH_RESET     = TOKEN_W'(1000000);
  localparam logic [TOKEN_W-1:0] MIN_BURST_RESET = '0;
  localparam logic [BYTES_W-1:0] LIMIT_RESET     = BYTES_W'(65536);
  localparam logic [BYTES_W-1:0] MAX_PKT_RESET   = BYTES_W'(65535);

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_QUEUED      = 3'd0,
    STATUS_DROP_BIG    = 3'd1,
    STATUS_DROP_FULL   = 3'd2,
    STATUS_SENT        = 3'd3,
    STATUS_HELD_OVER   = 3'd4,
    STATUS_HELD_BEHIND = 3'd5,
    STATUS_RESTARTED   = 3'd6
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RATE      = 3'd0,
    CFG_PEAK      = 3'd1,
    CFG_DEPTH     = 3'd2,
    CFG_MIN_BURST = 3'd3,
    CFG_LIMIT     = 3'd4,
    CFG_MAX_PKT   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [RATE_W-1:0]  peak;
    logic [TOKEN_W-1:0] depth;
    logic [TOKEN_W-1:0] min_burst;
    logic [BYTES_W-1:0] backlog_limit;
    logic [BYTES_W-1:0] max_packet;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLAMP,
    S_FILL,
    S_DIV_PEAK,
    S_DIV_MAIN,
    S_DECIDE,
    S_RESULT
  } state_t;

endpackage

@@ hw/rtl/drtbs_cfg.sv @@
module drtbs_cfg import drtbs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // Writes are taken whenever out of reset; out-of-range indexes are ignored
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate          <= RATE_RESET;
      cfg.peak          <= PEAK_RESET;
      cfg.depth         <= DEPTH_RESET;
      cfg.min_burst     <= MIN_BURST_RESET;
      cfg.backlog_limit <= LIMIT_RESET;
      cfg.max_packet    <= MAX_PKT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RATE:      cfg.rate          <= cfg_data[RATE_W-1:0];
        CFG_PEAK:      cfg.peak          <= cfg_data[RATE_W-1:0];
        CFG_DEPTH:     cfg.depth         <= cfg_data[TOKEN_W-1:0];
        CFG_MIN_BURST: cfg.min_burst     <= cfg_data[TOKEN_W-1:0];
        CFG_LIMIT:     cfg.backlog_limit <= cfg_data[BYTES_W-1:0];
        CFG_MAX_PKT:   cfg.max_packet    <= cfg_data[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/drtbs_div.sv @@
module drtbs_div import drtbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [PRODUCT_W-1:0] dividend,
  input  logic [RATE_W-1:0]    divisor,
  output div_stat_t            stat,
  output logic [PRODUCT_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PRODUCT_W - 1);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W-1:0]    rem;
  logic [PRODUCT_W-1:0] quo;
  logic [RATE_W-1:0]    dvs;
  logic [RATE_W:0]      trial;
  logic [RATE_W+1:0]    diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, try a subtract.
  // A zero divisor always fits, so the quotient comes out all ones.
  assign trial = {rem, quo[PRODUCT_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign fits  = !diff[RATE_W+1];

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

  // Step counter and handshake flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo <= {quo[PRODUCT_W-2:0], fits};
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done not a single pulse");
  assert property (@(posedge clk) disable iff (rst) (!busy && !start) |=> $stable(quo))
    else $error("quotient changed while divider idle");
`endif

endmodule

@@ hw/rtl/dual_rate_token_bucket_shaper.sv @@
// Dual-rate token bucket shaper, tokens held as nanoseconds.
// Input channel (in_valid/in_stall): opcode, packet_length, now_ns. A transaction
// is taken when in_valid is high and in_stall is low. One item is worked at a time;
// in_stall stays high from the transaction until its result is registered.
// Output channel (out_valid/out_stall): status, backlog_bytes, overlimit_count,
// one result per item (the unused opcode gives none). The result sits in an output
// register, so the next item can be taken while the receiver still stalls it.
// Config channel (cfg_valid/cfg_ready): six registers, to be written only while idle
// (the block does not enforce this); ready whenever rst is low.
// States per item, from transaction to the next possible transaction:
//   enqueue, restart, dequeue with clock behind: decode, result; unused opcode: decode
//   dequeue: decode, clamp, fill, peak divide (peak on), main divide, decide, result
// The dequeue path uses one radix-2 divider (46 steps) computing length*1e9/rate
// once per active bucket.
// The result shows on the outputs in the cycle the block is ready for the next item.
// Reset (rst, synchronous) loads the register defaults, clears tokens, checkpoint,
// backlog and overlimit count, and empties the output register; in_stall is high
// and cfg_ready low while rst is high.
// While out_stall holds the output register full, a finished result waits inside.
module dual_rate_token_bucket_shaper import drtbs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OPCODE_W-1:0]    opcode,
  input  logic [LEN_W-1:0]       packet_length,
  input  logic [TIME_W-1:0]      now_ns,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [BYTES_W-1:0]     backlog_bytes,
  output logic [BYTES_W-1:0]     overlimit_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                 cfg;
  state_t               state;
  state_t               state_next;
  div_stat_t            div_stat;
  logic                 div_start;
  logic [RATE_W-1:0]    div_divisor;
  logic [PRODUCT_W-1:0] quotient;
  logic                 load_out;

  // Captured item and working registers
  opcode_t              op_r;
  logic [LEN_W-1:0]     len_r;
  logic [TIME_W-1:0]    now_r;
  logic [TIME_W-1:0]    elapsed_r;
  logic [PRODUCT_W-1:0] product_r;
  logic [TOKEN_W-1:0]   refill_r;
  logic [TOKEN_W-1:0]   main_lvl;
  logic [TOKEN_W-1:0]   peak_lvl;
  logic [TOKEN_W-1:0]   main_left;
  logic [TOKEN_W-1:0]   peak_left;
  logic                 main_ok;
  logic                 peak_ok;
  status_t              res_status;

  // Architected state
  logic [TOKEN_W-1:0]   main_tokens;
  logic [TOKEN_W-1:0]   peak_tokens;
  logic [TIME_W-1:0]    checkpoint_time;
  logic [BYTES_W-1:0]   queued_bytes;
  logic [BYTES_W-1:0]   refusal_count;

  // Datapath terms
  logic                 peak_on;
  logic                 too_big;
  logic [BYTES_W:0]     enq_sum;
  logic                 over_limit;
  logic                 behind;
  logic [TIME_W-1:0]    elapsed;
  logic                 refill_big;
  logic [TOKEN_W:0]     main_sum;
  logic [TOKEN_W:0]     peak_sum;
  logic [TOKEN_W-1:0]   main_fill;
  logic [TOKEN_W-1:0]   peak_fill;
  logic [TOKEN_W-1:0]   lvl_sel;
  logic                 covers;
  logic [TOKEN_W-1:0]   left;
  logic                 send_ok;
  logic [BYTES_W-1:0]   backlog_drop;

  drtbs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  drtbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product_r),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Enqueue checks
  assign peak_on    = (cfg.peak != '0);
  assign too_big    = BYTES_W'(len_r) > cfg.max_packet;
  assign enq_sum    = {1'b0, queued_bytes} + (BYTES_W + 1)'(len_r);
  assign over_limit = enq_sum > {1'b0, cfg.backlog_limit};

  // Elapsed time and refill
  assign behind     = now_r < checkpoint_time;
  assign elapsed    = now_r - checkpoint_time;
  assign refill_big = elapsed_r > TIME_W'(cfg.depth);

  // Bucket levels before the charge
  assign main_sum  = {1'b0, refill_r} + {1'b0, main_tokens};
  assign peak_sum  = {1'b0, refill_r} + {1'b0, peak_tokens};
  assign main_fill = (main_sum > {1'b0, cfg.depth})     ? cfg.depth     : main_sum[TOKEN_W-1:0];
  assign peak_fill = (peak_sum > {1'b0, cfg.min_burst}) ? cfg.min_burst : peak_sum[TOKEN_W-1:0];

  // Shared charge compare for whichever bucket the divider just served
  assign lvl_sel = (state == S_DIV_PEAK) ? peak_lvl : main_lvl;
  assign covers  = PRODUCT_W'(lvl_sel) >= quotient;
  assign left    = lvl_sel - quotient[TOKEN_W-1:0];

  assign send_ok      = main_ok && peak_ok;
  assign backlog_drop = (queued_bytes > BYTES_W'(len_r)) ?
                        (queued_bytes - BYTES_W'(len_r)) : '0;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, divider control and output load
  always_comb begin
    state_next  = state;
    div_start   = 1'b0;
    div_divisor = cfg.rate;
    load_out    = 1'b0;
    in_stall    = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = rst;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_r)
          OP_ENQUEUE, OP_RESTART: state_next = S_RESULT;
          OP_DEQUEUE:             state_next = behind ? S_RESULT : S_CLAMP;
          default:                state_next = S_IDLE;
        endcase
      end
      S_CLAMP: begin
        state_next = S_FILL;
      end
      S_FILL: begin
        div_start = 1'b1;
        if (peak_on) begin
          div_divisor = cfg.peak;
          state_next  = S_DIV_PEAK;
        end else begin
          state_next = S_DIV_MAIN;
        end
      end
      S_DIV_PEAK: begin
        if (div_stat.done) begin
          div_start  = 1'b1;
          state_next = S_DIV_MAIN;
        end
      end
      S_DIV_MAIN: begin
        if (div_stat.done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Tokens, checkpoint, backlog, refusal count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      main_tokens     <= '0;
      peak_tokens     <= '0;
      checkpoint_time <= '0;
      queued_bytes    <= '0;
      refusal_count   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_DECODE: begin
          case (op_r)
            OP_ENQUEUE: begin
              if (!too_big && !over_limit) begin
                queued_bytes <= enq_sum[BYTES_W-1:0];
              end
            end
            OP_RESTART: begin
              main_tokens     <= cfg.depth;
              peak_tokens     <= cfg.min_burst;
              checkpoint_time <= now_r;
              queued_bytes    <= '0;
            end
            default: ;
          endcase
        end
        S_DECIDE: begin
          if (send_ok) begin
            checkpoint_time <= now_r;
            main_tokens     <= main_left;
            peak_tokens     <= peak_left;
            queued_bytes    <= backlog_drop;
          end else begin
            refusal_count <= refusal_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Item capture, working registers and output payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r  <= opcode_t'(opcode);
      len_r <= packet_length;
      now_r <= now_ns;
    end
    case (state)
      S_DECODE: begin
        elapsed_r <= elapsed;
        product_r <= PRODUCT_W'(len_r) * PRODUCT_W'(NS_PER_SEC);
        case (op_r)
          OP_ENQUEUE: begin
            if (too_big) begin
              res_status <= STATUS_DROP_BIG;
            end else if (over_limit) begin
              res_status <= STATUS_DROP_FULL;
            end else begin
              res_status <= STATUS_QUEUED;
            end
          end
          OP_DEQUEUE: res_status <= STATUS_HELD_BEHIND;
          OP_RESTART: res_status <= STATUS_RESTARTED;
          default: ;
        endcase
      end
      S_CLAMP: begin
        refill_r <= refill_big ? cfg.depth : elapsed_r[TOKEN_W-1:0];
      end
      S_FILL: begin
        main_lvl <= main_fill;
        peak_lvl <= peak_fill;
        if (!peak_on) begin
          peak_ok   <= 1'b1;
          peak_left <= '0;
        end
      end
      S_DIV_PEAK: begin
        if (div_stat.done) begin
          peak_ok   <= covers;
          peak_left <= left;
        end
      end
      S_DIV_MAIN: begin
        if (div_stat.done) begin
          main_ok   <= covers;
          main_left <= left;
        end
      end
      S_DECIDE: begin
        res_status <= send_ok ? STATUS_SENT : STATUS_HELD_OVER;
      end
      default: ;
    endcase
    if (load_out) begin
      status          <= res_status;
      backlog_bytes   <= queued_bytes;
      overlimit_count <= refusal_count;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    (refusal_count != $past(refusal_count)) |-> (refusal_count == $past(refusal_count) + 1'b1))
    else $error("overlimit count moved by more than one");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && send_ok) |=> (checkpoint_time == $past(now_r)))
    else $error("checkpoint not moved on send");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && out_valid && out_stall) |=> (state == S_RESULT && out_valid))
    else $error("result overwrote a stalled output");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE && op_r == OP_DEQUEUE && behind) |=>
      ($stable(main_tokens) && $stable(peak_tokens) && $stable(refusal_count)))
    else $error("clock-behind dequeue changed bucket state");
`endif

endmodule
